### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition now implies consequence in the same cycle
`define BDO_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// condition now implies consequence in the next cycle
`define BDO_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDO_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define BDO_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

### rtl/bdo_pkg.sv
`default_nettype none
package bdo_pkg;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RES    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IND    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUS    = 4'd3;

    localparam int LIMIT_DEFAULT = 5000;
    localparam int LOW_BUS_MV    = 1000;
    localparam int MV_PER_V      = 1000;
    localparam int Q15_SHIFT     = 15;
    localparam int EMF_MAX       = 32767;
    localparam int EMF_MIN       = -32768;
    localparam int LIMIT_W       = 33;
    localparam int DIVISOR_W     = 32;

    typedef enum logic [7:0] {
        S_LSTART = 8'b0000_0001,
        S_LIMIT  = 8'b0000_0010,
        S_IDLE   = 8'b0000_0100,
        S_PREP   = 8'b0000_1000,
        S_START  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_SQRT   = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        KIND_PRIME  = 2'd0,
        KIND_GLITCH = 2'd1,
        KIND_NORMAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic  clear;
        logic  capture;
        logic  commit;
        kind_t kind;
        logic  start;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic sat;
    } lane_stat_t;
endpackage
`default_nettype wire

### rtl/bdo_if.sv
`default_nettype none
interface bdo_in_if #(parameter int CURRENT_BITS = 18);
    logic                           valid;
    logic                           ready;
    logic signed [15:0]             volt_alpha;
    logic signed [15:0]             volt_beta;
    logic signed [CURRENT_BITS-1:0] amp_alpha_ma;
    logic signed [CURRENT_BITS-1:0] amp_beta_ma;
    modport source (output valid, volt_alpha, volt_beta, amp_alpha_ma, amp_beta_ma,
                    input ready);
    modport sink (input valid, volt_alpha, volt_beta, amp_alpha_ma, amp_beta_ma,
                  output ready);
endinterface

interface bdo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] bemf_a;
    logic signed [15:0] bemf_b;
    logic        [15:0] emf_magnitude;
    logic               saturated_flag;
    logic               glitch_flag;
    logic               valid_flag;
    modport source (output valid, bemf_a, bemf_b, emf_magnitude, saturated_flag,
                    glitch_flag, valid_flag, input ready);
    modport sink (input valid, bemf_a, bemf_b, emf_magnitude, saturated_flag,
                  glitch_flag, valid_flag, output ready);
endinterface
`default_nettype wire

### rtl/bdo_div.sv
`default_nettype none
module bdo_div #(
    parameter int NW = 51,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               busy,
    output logic [NW-1:0]      quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

### rtl/bdo_lane.sv
`default_nettype none
module bdo_lane
    import bdo_pkg::*;
#(
    parameter int CURRENT_BITS = 18
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lane_ctrl_t                     ctrl,
    input  wire logic signed [15:0]             volt,
    input  wire logic signed [CURRENT_BITS-1:0] amp,
    input  wire logic [15:0]                    res_mohm,
    input  wire logic [15:0]                    ind_uh,
    input  wire logic [DIVISOR_W-1:0]           res_div,
    input  wire logic [DIVISOR_W-1:0]           ind_div,
    output logic [CURRENT_BITS:0]               step_mag,
    output logic signed [15:0]                  emf,
    output lane_stat_t                          stat
);
    localparam int CB = CURRENT_BITS;
    localparam int SW = CB + 2;
    localparam int RPW = CB + 17;
    localparam int LPW = SW + 17;
    localparam int NW = CB + 33;
    localparam int EW = NW + 2;

    logic signed [CB-1:0]  last_reg;
    logic signed [CB-1:0]  cur_reg;
    logic signed [15:0]    volt_reg;
    logic signed [CB:0]    step_reg;
    logic signed [SW-1:0]  slope_reg;
    logic signed [SW-1:0]  slope_next;
    logic signed [SW:0]    slope_diff;
    logic signed [RPW-1:0] rprod_reg;
    logic signed [LPW-1:0] lprod_reg;
    logic [RPW-1:0]        rabs;
    logic [LPW-1:0]        labs;
    logic [NW-1:0]         rnum;
    logic [NW-1:0]         lnum;
    logic [NW-1:0]         rq;
    logic [NW-1:0]         lq;
    logic                  rbusy;
    logic                  lbusy;
    logic signed [NW:0]    rq_s;
    logic signed [NW:0]    lq_s;
    logic signed [EW-1:0]  emf_wide;

    // quarter low-pass on the current step, floor shift
    assign slope_diff = (SW+1)'(step_reg) - (SW+1)'(slope_reg);
    assign slope_next = slope_reg + SW'(slope_diff >>> 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            slope_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            last_reg  <= '0;
            slope_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            last_reg <= cur_reg;
            unique case (ctrl.kind)
                KIND_GLITCH: slope_reg <= '0;
                KIND_NORMAL: slope_reg <= slope_next;
                default:     slope_reg <= slope_reg;
            endcase
        end
    end

    // sample capture and products
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cur_reg  <= amp;
            volt_reg <= volt;
            step_reg <= (CB+1)'(amp) - (CB+1)'(last_reg);
        end
        if (ctrl.commit)
        begin
            rprod_reg <= $signed({1'b0, res_mohm}) * (RPW)'(cur_reg);
            lprod_reg <= $signed({1'b0, ind_uh}) * (LPW)'(slope_next);
        end
    end

    assign step_mag = step_reg[CB] ? (CB+1)'(-step_reg) : (CB+1)'(step_reg);

    // magnitudes scaled to q15 for the dividers
    assign rabs = rprod_reg[RPW-1] ? RPW'(-rprod_reg) : RPW'(rprod_reg);
    assign labs = lprod_reg[LPW-1] ? LPW'(-lprod_reg) : LPW'(lprod_reg);
    assign rnum = NW'(rabs) << Q15_SHIFT;
    assign lnum = NW'(labs) << Q15_SHIFT;

    bdo_div #(.NW(NW), .DW(DIVISOR_W)) u_rdiv (
        .clk(clk), .rst_n(rst_n), .start(ctrl.start), .dividend(rnum),
        .divisor(res_div), .busy(rbusy), .quotient(rq)
    );

    bdo_div #(.NW(NW), .DW(DIVISOR_W)) u_ldiv (
        .clk(clk), .rst_n(rst_n), .start(ctrl.start), .dividend(lnum),
        .divisor(ind_div), .busy(lbusy), .quotient(lq)
    );

    // signs restored, truncation toward zero
    assign rq_s = rprod_reg[RPW-1] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    assign lq_s = lprod_reg[LPW-1] ? -$signed({1'b0, lq}) : $signed({1'b0, lq});
    assign emf_wide = EW'(volt_reg) - EW'(rq_s) - EW'(lq_s);

    // clamp to q15
    always_comb
    begin
        stat.busy = rbusy | lbusy;
        stat.sat  = 1'b0;
        emf       = emf_wide[15:0];
        if (emf_wide > EW'(EMF_MAX))
        begin
            stat.sat = 1'b1;
            emf      = 16'(EMF_MAX);
        end
        else if (emf_wide < EW'(EMF_MIN))
        begin
            stat.sat = 1'b1;
            emf      = 16'(EMF_MIN);
        end
    end
endmodule
`default_nettype wire

### rtl/bdo_merge.sv
`default_nettype none
module bdo_merge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [15:0] emf_a,
    input  wire logic signed [15:0] emf_b,
    output logic                    busy,
    output logic [15:0]             magnitude
);
    logic [31:0] sqa_reg;
    logic [31:0] sqb_reg;
    logic [31:0] x_reg;
    logic [31:0] r_reg;
    logic [31:0] bit_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic [31:0] trial;

    assign trial = r_reg + bit_reg;

    // squares, sum, then a bit-serial square root; a start restarts it even while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 2'd1;
        end
        else if (busy_reg)
        begin
            if (phase_reg == 2'd1)
            begin
                phase_reg <= 2'd2;
            end
            else if (bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sqa_reg <= 32'(emf_a) * 32'(emf_a);
            sqb_reg <= 32'(emf_b) * 32'(emf_b);
        end
        else if (busy_reg && phase_reg == 2'd1)
        begin
            x_reg   <= sqa_reg + sqb_reg;
            r_reg   <= '0;
            bit_reg <= 32'h4000_0000;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy      = busy_reg;
    assign magnitude = r_reg[15:0];
endmodule
`default_nettype wire

### rtl/back_emf_observer_core.sv
// back-emf observer, alpha/beta frame
// in_ch carries one sample a beat: q15 voltages and currents in milliamperes.
// out_ch returns one beat per sample: clamped q15 emf pair, its magnitude and flags.
// the cfg port writes one register per cycle when cfg_wr_en is high; any write to
// a listed register clears the observer state, and the following sample only primes.
// after reset or a write the current-step limit is worked out by a bit-serial divider,
// during which in_ch.ready stays low.
// a priming, outlier or low-bus sample passes from acceptance through S_PREP and
// S_FIN to its beat; a normal sample also passes S_START, S_DIV and S_SQRT, waiting
// on the bit-serial dividers in the two axis lanes and the 16-step root.
// one sample is in work at a time; a new sample is taken while a finished beat still
// waits at the output, and work stalls at the end while the receiver holds ready low.
`include "assert_macros.svh"
`default_nettype none
module back_emf_observer_core
    import bdo_pkg::*;
#(
    parameter int CURRENT_BITS = 18
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    bdo_in_if.sink                      in_ch,
    bdo_out_if.source                   out_ch
);
    localparam int CMP_W = (CURRENT_BITS + 1 > LIMIT_W) ? CURRENT_BITS + 2 : LIMIT_W + 1;

    state_t state_reg;
    state_t state_next;

    logic [15:0] res_reg, ind_reg, per_reg, bus_reg;
    logic [DIVISOR_W-1:0] rdiv_reg, ldiv_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic primed_reg, glitch_reg, sat_reg, valid_reg;
    logic signed [15:0] res_a_reg, res_b_reg;
    logic [15:0] res_m_reg;
    logic out_valid_reg;
    logic signed [15:0] o_a_reg, o_b_reg;
    logic [15:0] o_m_reg;
    logic o_sat_reg, o_gl_reg, o_val_reg;

    logic cfg_hit, accept, lim_busy, merge_busy, merge_start, glitch_hit, low_bus;
    logic [31:0] lim_q;
    logic [CURRENT_BITS:0] mag_a, mag_b;
    logic signed [15:0] emf_a, emf_b;
    logic [15:0] mag;
    lane_stat_t stat_a, stat_b;
    lane_ctrl_t lctrl;

    assign cfg_hit = cfg_wr_en && (cfg_index == REG_RES || cfg_index == REG_IND
                     || cfg_index == REG_PERIOD || cfg_index == REG_BUS);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign glitch_hit = (CMP_W'(mag_a) > CMP_W'(limit_reg))
                        || (CMP_W'(mag_b) > CMP_W'(limit_reg));
    assign low_bus = bus_reg < 16'(LOW_BUS_MV);

    // step limit divider, run after reset and writes
    bdo_div #(.NW(32), .DW(16)) u_lim (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_LSTART),
        .dividend(32'(bus_reg) * 32'(per_reg)), .divisor(ind_reg), .busy(lim_busy),
        .quotient(lim_q)
    );

    // lane commands
    always_comb
    begin
        lctrl.clear   = cfg_hit;
        lctrl.capture = accept;
        lctrl.commit  = (state_reg == S_PREP);
        lctrl.kind    = !primed_reg ? KIND_PRIME : (glitch_hit ? KIND_GLITCH : KIND_NORMAL);
        lctrl.start   = (state_reg == S_START);
    end

    bdo_lane #(.CURRENT_BITS(CURRENT_BITS)) u_lane_a (
        .clk(clk), .rst_n(rst_n), .ctrl(lctrl), .volt(in_ch.volt_alpha),
        .amp(in_ch.amp_alpha_ma), .res_mohm(res_reg), .ind_uh(ind_reg),
        .res_div(rdiv_reg), .ind_div(ldiv_reg), .step_mag(mag_a), .emf(emf_a),
        .stat(stat_a)
    );

    bdo_lane #(.CURRENT_BITS(CURRENT_BITS)) u_lane_b (
        .clk(clk), .rst_n(rst_n), .ctrl(lctrl), .volt(in_ch.volt_beta),
        .amp(in_ch.amp_beta_ma), .res_mohm(res_reg), .ind_uh(ind_reg),
        .res_div(rdiv_reg), .ind_div(ldiv_reg), .step_mag(mag_b), .emf(emf_b),
        .stat(stat_b)
    );

    assign merge_start = (state_reg == S_DIV) && !stat_a.busy && !stat_b.busy;

    bdo_merge u_merge (
        .clk(clk), .rst_n(rst_n), .start(merge_start), .emf_a(emf_a), .emf_b(emf_b),
        .busy(merge_busy), .magnitude(mag)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LSTART: state_next = S_LIMIT;
            S_LIMIT:  if (!lim_busy) state_next = S_IDLE;
            S_IDLE:   if (accept) state_next = S_PREP;
            S_PREP:   state_next = (primed_reg && !glitch_hit && !low_bus) ? S_START : S_FIN;
            S_START:  state_next = S_DIV;
            S_DIV:    if (merge_start) state_next = S_SQRT;
            S_SQRT:   if (!merge_busy) state_next = S_FIN;
            S_FIN:    if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default:  state_next = S_LSTART;
        endcase
        if (cfg_hit)
        begin
            state_next = S_LSTART;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LSTART;
            res_reg       <= '0;
            ind_reg       <= '0;
            per_reg       <= 16'd1;
            bus_reg       <= '0;
            primed_reg    <= 1'b0;
            glitch_reg    <= 1'b0;
            sat_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_hit)
            begin
                primed_reg <= 1'b0;
                glitch_reg <= 1'b0;
                sat_reg    <= 1'b0;
                valid_reg  <= 1'b0;
                unique case (cfg_index)
                    REG_RES:    res_reg <= cfg_data;
                    REG_IND:    ind_reg <= cfg_data;
                    REG_PERIOD: per_reg <= (cfg_data == '0) ? 16'd1 : cfg_data;
                    default:    bus_reg <= cfg_data;
                endcase
            end
            else
            begin
                // flag updates
                if (state_reg == S_PREP)
                begin
                    primed_reg <= 1'b1;
                    if (primed_reg && glitch_hit)
                    begin
                        glitch_reg <= 1'b1;
                        valid_reg  <= 1'b0;
                    end
                end
                if (merge_start)
                begin
                    sat_reg   <= stat_a.sat | stat_b.sat;
                    valid_reg <= !(stat_a.sat | stat_b.sat | glitch_reg);
                end
                if (state_reg == S_FIN && (!out_valid_reg || out_ch.ready))
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LSTART)
        begin
            rdiv_reg <= DIVISOR_W'(bus_reg * 26'(MV_PER_V));
            ldiv_reg <= DIVISOR_W'(bus_reg) * DIVISOR_W'(per_reg);
        end
        if (state_reg == S_LIMIT && !lim_busy)
        begin
            limit_reg <= (ind_reg == '0 || lim_q == '0) ? LIMIT_W'(LIMIT_DEFAULT)
                                                         : {lim_q, 1'b0};
        end
        if (state_reg == S_PREP)
        begin
            res_a_reg <= '0;
            res_b_reg <= '0;
            res_m_reg <= '0;
        end
        if (state_reg == S_SQRT && !merge_busy)
        begin
            res_a_reg <= emf_a;
            res_b_reg <= emf_b;
            res_m_reg <= mag;
        end
        if (state_reg == S_FIN && (!out_valid_reg || out_ch.ready))
        begin
            o_a_reg   <= res_a_reg;
            o_b_reg   <= res_b_reg;
            o_m_reg   <= res_m_reg;
            o_sat_reg <= sat_reg;
            o_gl_reg  <= glitch_reg;
            o_val_reg <= valid_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.bemf_a         = o_a_reg;
    assign out_ch.bemf_b         = o_b_reg;
    assign out_ch.emf_magnitude  = o_m_reg;
    assign out_ch.saturated_flag = o_sat_reg;
    assign out_ch.glitch_flag    = o_gl_reg;
    assign out_ch.valid_flag     = o_val_reg;

    // checks
    `BDO_ASSERT_SAME(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `BDO_ASSERT_NEXT(a_accept_prep, clk, rst_n, accept && !cfg_hit, state_reg == S_PREP)
    `BDO_ASSERT_NEXT(a_glitch_sticky, clk, rst_n, glitch_reg && !cfg_hit, glitch_reg)
endmodule
`default_nettype wire

### test/back_emf_observer_core_tb.sv
`default_nettype none
module back_emf_observer_core_tb;
    import bdo_pkg::*;

    localparam int  AMP_W       = 18;
    localparam int  AMP_MAX     = 131071;
    localparam int  AMP_MIN     = -131072;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 120;

    typedef struct {
        logic signed [15:0] emf_a;
        logic signed [15:0] emf_b;
        logic [15:0]        mag;
        logic               sat;
        logic               glitch;
        logic               trust;
    } emf_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bdo_in_if #(.CURRENT_BITS(AMP_W)) in_ch ();
    bdo_out_if out_ch ();

    back_emf_observer_core #(.CURRENT_BITS(AMP_W)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // observer model state
    longint res_mohm, ind_uh, per_us, bus_mv;
    longint prev_ia, prev_ib, slope_a, slope_b;
    bit     is_primed, glitch_seen, sat_hold, trust_hold;
    longint emf_a_now, emf_b_now;

    emf_beat_t emf_beats_due[$];
    int  error_count;
    int  cycle_count;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  hold_left;
    longint walk_a, walk_b;

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void clear_model();
        prev_ia = 0;
        prev_ib = 0;
        slope_a = 0;
        slope_b = 0;
        is_primed = 0;
        glitch_seen = 0;
        sat_hold = 0;
        trust_hold = 0;
        emf_a_now = 0;
        emf_b_now = 0;
    endfunction

    function automatic longint root_floor(longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic longint clamp_emf(longint x, ref bit sat);
        if (x > EMF_MAX)
        begin
            sat = 1;
            return EMF_MAX;
        end
        if (x < EMF_MIN)
        begin
            sat = 1;
            return EMF_MIN;
        end
        return x;
    endfunction

    function automatic emf_beat_t pack_beat();
        emf_beat_t b;
        b.emf_a  = emf_a_now[15:0];
        b.emf_b  = emf_b_now[15:0];
        b.mag    = 16'(root_floor(emf_a_now * emf_a_now + emf_b_now * emf_b_now));
        b.sat    = sat_hold;
        b.glitch = glitch_seen;
        b.trust  = trust_hold;
        return b;
    endfunction

    function automatic longint step_limit();
        longint phys;
        phys = (ind_uh > 0) ? (bus_mv * per_us) / ind_uh : 0;
        return (phys > 0) ? phys * 2 : LIMIT_DEFAULT;
    endfunction

    // emf estimate for one accepted sample
    function automatic emf_beat_t predict_emf(longint va, longint vb, longint ia, longint ib);
        longint da, db, lim, ra, rb, la, lb;
        bit sat;
        sat = 0;
        if (!is_primed)
        begin
            prev_ia = ia;
            prev_ib = ib;
            emf_a_now = 0;
            emf_b_now = 0;
            is_primed = 1;
            return pack_beat();
        end
        da = ia - prev_ia;
        db = ib - prev_ib;
        lim = step_limit();
        // current outlier
        if (da > lim || da < -lim || db > lim || db < -lim)
        begin
            glitch_seen = 1;
            trust_hold = 0;
            emf_a_now = 0;
            emf_b_now = 0;
            prev_ia = ia;
            prev_ib = ib;
            slope_a = 0;
            slope_b = 0;
            return pack_beat();
        end
        slope_a += (da - slope_a) >>> 2;
        slope_b += (db - slope_b) >>> 2;
        prev_ia = ia;
        prev_ib = ib;
        // low bus
        if (bus_mv < LOW_BUS_MV)
        begin
            emf_a_now = 0;
            emf_b_now = 0;
            return pack_beat();
        end
        ra = (res_mohm * ia * 32768) / (MV_PER_V * bus_mv);
        rb = (res_mohm * ib * 32768) / (MV_PER_V * bus_mv);
        la = (ind_uh * slope_a * 32768) / (per_us * bus_mv);
        lb = (ind_uh * slope_b * 32768) / (per_us * bus_mv);
        emf_a_now = clamp_emf(va - ra - la, sat);
        emf_b_now = clamp_emf(vb - rb - lb, sat);
        sat_hold = sat;
        trust_hold = !(sat_hold || glitch_seen);
        return pack_beat();
    endfunction

    // receiver side: random stall, or a long counted hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready = 1'b0;
            hold_left--;
        end
        else
            out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
    end

    // result check
    always @(posedge clk)
    begin
        emf_beat_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (emf_beats_due.size() == 0)
            begin
                $display("%0t: unexpected beat emf %0d %0d", $time,
                         out_ch.bemf_a, out_ch.bemf_b);
                error_count++;
            end
            else
            begin
                e = emf_beats_due.pop_front();
                if (out_ch.bemf_a !== e.emf_a)
                begin
                    $display("%0t: bemf_a expected %0d actual %0d", $time,
                             e.emf_a, out_ch.bemf_a);
                    error_count++;
                end
                if (out_ch.bemf_b !== e.emf_b)
                begin
                    $display("%0t: bemf_b expected %0d actual %0d", $time,
                             e.emf_b, out_ch.bemf_b);
                    error_count++;
                end
                if (out_ch.emf_magnitude !== e.mag)
                begin
                    $display("%0t: emf_magnitude expected %0d actual %0d", $time,
                             e.mag, out_ch.emf_magnitude);
                    error_count++;
                end
                if (out_ch.saturated_flag !== e.sat)
                begin
                    $display("%0t: saturated_flag expected %0b actual %0b", $time,
                             e.sat, out_ch.saturated_flag);
                    error_count++;
                end
                if (out_ch.glitch_flag !== e.glitch)
                begin
                    $display("%0t: glitch_flag expected %0b actual %0b", $time,
                             e.glitch, out_ch.glitch_flag);
                    error_count++;
                end
                if (out_ch.valid_flag !== e.trust)
                begin
                    $display("%0t: valid_flag expected %0b actual %0b", $time,
                             e.trust, out_ch.valid_flag);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one sample beat, with random sender gaps
    task automatic send_sample(longint va, longint vb, longint ia, longint ib);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.volt_alpha = va[15:0];
        in_ch.volt_beta = vb[15:0];
        in_ch.amp_alpha_ma = ia[AMP_W-1:0];
        in_ch.amp_beta_ma = ib[AMP_W-1:0];
        do
            @(posedge clk);
        while (!in_ch.ready);
        emf_beats_due.push_back(predict_emf(va, vb, ia, ib));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (emf_beats_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, longint val);
        wait_idle();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val[15:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_RES:    res_mohm = val;
            REG_IND:    ind_uh = val;
            REG_PERIOD: per_us = (val == 0) ? 1 : val;
            REG_BUS:    bus_mv = val;
            default:    return;
        endcase
        clear_model();
    endtask

    task automatic set_motor(longint r, longint l, longint p, longint v);
        write_reg(REG_RES, r);
        write_reg(REG_IND, l);
        write_reg(REG_PERIOD, p);
        write_reg(REG_BUS, v);
        walk_a = 0;
        walk_b = 0;
    endtask

    function automatic longint rand_full(int w);
        longint v;
        v = $urandom_range(0, (1 << w) - 1);
        return v - ((v >> (w - 1)) << w);
    endfunction

    function automatic longint bound_amp(longint x);
        if (x > AMP_MAX)
            return AMP_MAX;
        if (x < AMP_MIN)
            return AMP_MIN;
        return x;
    endfunction

    // next sample: mostly a bounded current walk, sometimes full-range noise
    task automatic send_walk();
        longint stride;
        stride = step_limit();
        if (stride > 20000)
            stride = 20000;
        if ($urandom_range(99) < 4)
        begin
            walk_a = rand_full(AMP_W);
            walk_b = rand_full(AMP_W);
        end
        else
        begin
            walk_a = bound_amp(walk_a + $urandom_range(0, 2 * stride) - stride);
            walk_b = bound_amp(walk_b + $urandom_range(0, 2 * stride) - stride);
        end
        send_sample(rand_full(16), rand_full(16), walk_a, walk_b);
    endtask

    task automatic random_motor();
        set_motor($urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(5, 200), $urandom_range(3000, 65535));
    endtask

    task automatic test_reset_defaults();
        // bus at zero after reset: priming, low-bus, then an outlier result
        send_sample(100, -100, 5, -5);
        send_sample(200, 300, 10, 20);
        send_sample(0, 0, 9000, 0);
    endtask

    task automatic test_directed();
        set_motor(0, 0, 0, 65535);
        send_sample(32767, -32768, 0, 0);
        send_sample(32767, -32768, 4000, -4000);
        send_sample(-32768, 32767, 4000, -4000);
        // large resistance drives both axes into clamp
        set_motor(65535, 65535, 65535, 65535);
        send_sample(0, 0, AMP_MAX, AMP_MIN);
        send_sample(0, 0, AMP_MAX - 10, AMP_MIN + 10);
        send_sample(32767, -32768, 0, 0);
        // zero limit quotient falls back to the default limit: small steps, no outlier
        set_motor(1000, 65535, 1, 1000);
        send_sample(100, 100, 0, 0);
        send_sample(100, 100, 3, 0);
        send_sample(100, 100, 4, 0);
        send_sample(100, 100, 4, 1);
        // bus just below and at the low-bus threshold
        set_motor(500, 100, 50, 999);
        send_sample(1000, 1000, 100, 100);
        send_sample(1000, 1000, 150, 50);
        write_reg(REG_BUS, 1000);
        send_sample(1000, 1000, 100, 100);
        send_sample(1000, 1000, 150, 50);
        // unlisted index leaves state alone
        write_reg(4'd7, 16'hffff);
        write_reg(4'd15, 0);
        send_sample(-500, 500, 160, 40);
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        src_idle_pct = idle;
        snk_stall_pct = stall;
        random_motor();
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 39)
                random_motor();
            send_walk();
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        random_motor();
        hold_left = 600;
        for (int k = 0; k < 20; k++)
            send_walk();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.volt_alpha = '0;
        in_ch.volt_beta = '0;
        in_ch.amp_alpha_ma = '0;
        in_ch.amp_beta_ma = '0;
        error_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_left = 0;
        res_mohm = 0;
        ind_uh = 0;
        per_us = 1;
        bus_mv = 0;
        clear_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed();
        test_random_phase(160, 0, 0);
        test_random_phase(150, 82, 0);
        test_random_phase(150, 0, 82);
        test_random_phase(150, 37, 37);
        test_backpressure();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && emf_beats_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/bdo_pkg.sv
rtl/bdo_if.sv
rtl/bdo_div.sv
rtl/bdo_lane.sv
rtl/bdo_merge.sv
rtl/back_emf_observer_core.sv
test/back_emf_observer_core_tb.sv
